@@ rtl/prpc_pkg.sv @@
// Package: shared types, op codes and the pixel operation functions of the raster op combiner.
`timescale 1ns / 1ps

package prpc_pkg;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned UOP_W   = 5;
	localparam int unsigned BOP_W   = 3;
	localparam int unsigned MODE_W  = 2;
	localparam int unsigned CIDX_W  = 3;
	localparam int unsigned CDATA_W = 5;

	// pixel depth codes
	localparam logic [MODE_W-1:0] MODE_1BPP = 2'd0;
	localparam logic [MODE_W-1:0] MODE_2BPP = 2'd1;
	localparam logic [MODE_W-1:0] MODE_4BPP = 2'd2;

	// binary op codes
	localparam logic [BOP_W-1:0] BOP_AND    = 3'd0;
	localparam logic [BOP_W-1:0] BOP_OR     = 3'd1;
	localparam logic [BOP_W-1:0] BOP_XOR    = 3'd2;
	localparam logic [BOP_W-1:0] BOP_FIRST  = 3'd3;
	localparam logic [BOP_W-1:0] BOP_SECOND = 3'd4;
	localparam logic [BOP_W-1:0] BOP_PMASK  = 3'd5;

	// unary codes above the colour range, as offsets from the colour count
	localparam logic [UOP_W-1:0] UOP_COPY   = 5'd0;
	localparam logic [UOP_W-1:0] UOP_NOT    = 5'd1;
	localparam logic [UOP_W-1:0] UOP_ZERO   = 5'd2;
	localparam logic [UOP_W-1:0] UOP_THRESH = 5'd3;

	// configuration register indexes
	localparam logic [CIDX_W-1:0] REG_PIXEL_MODE  = 3'd0;
	localparam logic [CIDX_W-1:0] REG_SOURCE_UOP  = 3'd1;
	localparam logic [CIDX_W-1:0] REG_MASK_UOP    = 3'd2;
	localparam logic [CIDX_W-1:0] REG_FIRST_BOP   = 3'd3;
	localparam logic [CIDX_W-1:0] REG_MIDDLE_UOP  = 3'd4;
	localparam logic [CIDX_W-1:0] REG_DEST_UOP    = 3'd5;
	localparam logic [CIDX_W-1:0] REG_SECOND_BOP  = 3'd6;
	localparam logic [CIDX_W-1:0] REG_FINAL_UOP   = 3'd7;

	localparam logic [UOP_W-1:0] UOP_RESET = 5'd2;
	localparam logic [BOP_W-1:0] BOP_RESET = 3'd3;

	typedef struct packed {
		logic [MODE_W-1:0] pixel_mode;
		logic [UOP_W-1:0]  source_uop;
		logic [UOP_W-1:0]  mask_uop;
		logic [BOP_W-1:0]  first_bop;
		logic [UOP_W-1:0]  middle_uop;
		logic [UOP_W-1:0]  dest_uop;
		logic [BOP_W-1:0]  second_bop;
		logic [UOP_W-1:0]  final_uop;
	} cfg_t;

	// controls of one combine stage
	typedef struct packed {
		logic [MODE_W-1:0] pixel_mode;
		logic [BOP_W-1:0]  bop;
		logic [UOP_W-1:0]  uop;
	} stage_ctl_t;

	// set every bit of a pixel group when any bit of it is set
	function automatic logic [BYTE_W-1:0] group_fill(input logic [BYTE_W-1:0] v,
			input logic [MODE_W-1:0] mode);
		logic [BYTE_W-1:0] r;
		r = '0;
		unique case (mode)
			MODE_1BPP: r = v;
			MODE_2BPP: begin
				if ((v & 8'h11) != 8'h00) r = r | 8'h11;
				if ((v & 8'h22) != 8'h00) r = r | 8'h22;
				if ((v & 8'h44) != 8'h00) r = r | 8'h44;
				if ((v & 8'h88) != 8'h00) r = r | 8'h88;
			end
			default: begin
				if ((v & 8'haa) != 8'h00) r = r | 8'haa;
				if ((v & 8'h55) != 8'h00) r = r | 8'h55;
			end
		endcase
		return r;
	endfunction

	function automatic logic [BYTE_W-1:0] colour_fill(input logic [3:0] c,
			input logic [MODE_W-1:0] mode);
		logic [BYTE_W-1:0] r;
		unique case (mode)
			MODE_1BPP: r = {BYTE_W{c[0]}};
			MODE_2BPP: r = {{4{c[1]}}, {4{c[0]}}};
			default:   r = {{2{c[0]}}, {2{c[2]}}, {2{c[1]}}, {2{c[3]}}};
		endcase
		return r;
	endfunction

	function automatic logic [BYTE_W-1:0] unary_op(input logic [UOP_W-1:0] op,
			input logic [BYTE_W-1:0] a, input logic [MODE_W-1:0] mode);
		logic [UOP_W-1:0]  p;
		logic [BYTE_W-1:0] r;
		unique case (mode)
			MODE_1BPP: p = 5'd2;
			MODE_2BPP: p = 5'd4;
			default:   p = 5'd16;
		endcase
		priority if (op < p)                r = colour_fill(op[3:0], mode);
		else if (op == p + UOP_COPY)        r = a;
		else if (op == p + UOP_NOT)         r = ~a;
		else if (op == p + UOP_ZERO)        r = '0;
		else if (op == p + UOP_THRESH)      r = group_fill(a, mode);
		else                                r = '0;
		return r;
	endfunction

	function automatic logic [BYTE_W-1:0] binary_op(input logic [BOP_W-1:0] op,
			input logic [BYTE_W-1:0] a, input logic [BYTE_W-1:0] b,
			input logic [MODE_W-1:0] mode);
		logic [BYTE_W-1:0] r;
		unique case (op)
			BOP_AND:    r = a & b;
			BOP_OR:     r = a | b;
			BOP_XOR:    r = a ^ b;
			BOP_FIRST:  r = a;
			BOP_SECOND: r = b;
			BOP_PMASK:  r = a & group_fill(b, mode);
			default:    r = '0;
		endcase
		return r;
	endfunction

endpackage

@@ rtl/prpc_cfg_regs.sv @@
// Configuration registers of the raster op combiner.
`timescale 1ns / 1ps

module prpc_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [prpc_pkg::CIDX_W-1:0]   cfg_index,
	input  logic [prpc_pkg::CDATA_W-1:0]  cfg_data,
	output prpc_pkg::cfg_t                cfg
);
	import prpc_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pixel_mode <= MODE_1BPP;
			cfg_q.source_uop <= UOP_RESET;
			cfg_q.mask_uop   <= UOP_RESET;
			cfg_q.first_bop  <= BOP_RESET;
			cfg_q.middle_uop <= UOP_RESET;
			cfg_q.dest_uop   <= UOP_RESET;
			cfg_q.second_bop <= BOP_RESET;
			cfg_q.final_uop  <= UOP_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PIXEL_MODE: cfg_q.pixel_mode <= cfg_data[MODE_W-1:0];
				REG_SOURCE_UOP: cfg_q.source_uop <= cfg_data[UOP_W-1:0];
				REG_MASK_UOP:   cfg_q.mask_uop   <= cfg_data[UOP_W-1:0];
				REG_FIRST_BOP:  cfg_q.first_bop  <= cfg_data[BOP_W-1:0];
				REG_MIDDLE_UOP: cfg_q.middle_uop <= cfg_data[UOP_W-1:0];
				REG_DEST_UOP:   cfg_q.dest_uop   <= cfg_data[UOP_W-1:0];
				REG_SECOND_BOP: cfg_q.second_bop <= cfg_data[BOP_W-1:0];
				REG_FINAL_UOP:  cfg_q.final_uop  <= cfg_data[UOP_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ rtl/prpc_front.sv @@
// First pipeline stage: unary ops on the source, mask and destination words.
`timescale 1ns / 1ps

module prpc_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic [prpc_pkg::BYTE_W-1:0]  src,
	input  logic [prpc_pkg::BYTE_W-1:0]  msk,
	input  logic [prpc_pkg::BYTE_W-1:0]  dst,
	input  prpc_pkg::cfg_t               cfg,
	output logic                         out_valid,
	output logic [prpc_pkg::BYTE_W-1:0]  s_out,
	output logic [prpc_pkg::BYTE_W-1:0]  m_out,
	output logic [prpc_pkg::BYTE_W-1:0]  d_out
);
	import prpc_pkg::*;

	logic              v_s1;
	logic [BYTE_W-1:0] s_s1;
	logic [BYTE_W-1:0] m_s1;
	logic [BYTE_W-1:0] d_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid) begin
			s_s1 <= unary_op(cfg.source_uop, src, cfg.pixel_mode);
			m_s1 <= unary_op(cfg.mask_uop, msk, cfg.pixel_mode);
			d_s1 <= unary_op(cfg.dest_uop, dst, cfg.pixel_mode);
		end
	end

	assign out_valid = v_s1;
	assign s_out     = s_s1;
	assign m_out     = m_s1;
	assign d_out     = d_s1;

endmodule

@@ rtl/prpc_combine.sv @@
// Combine stage: one binary op followed by one unary op, registered.
`timescale 1ns / 1ps

module prpc_combine (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic [prpc_pkg::BYTE_W-1:0]  a,
	input  logic [prpc_pkg::BYTE_W-1:0]  b,
	input  prpc_pkg::stage_ctl_t         ctl,
	output logic                         out_valid,
	output logic [prpc_pkg::BYTE_W-1:0]  y
);
	import prpc_pkg::*;

	logic              v_q;
	logic [BYTE_W-1:0] y_q;
	logic [BYTE_W-1:0] comb;

	assign comb = binary_op(ctl.bop, a, b, ctl.pixel_mode);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else begin
			v_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid) begin
			y_q <= unary_op(ctl.uop, comb, ctl.pixel_mode);
		end
	end

	assign out_valid = v_q;
	assign y         = y_q;

endmodule

@@ rtl/packed_pixel_raster_op_combiner_top.sv @@
// Top level of the packed pixel raster op combiner.
`timescale 1ns / 1ps

// Takes one source, mask and destination word per cycle whenever start is high
// (busy stays low, so every start is taken) and returns the combined word on
// result_byte after the three register stages, with done high for one cycle
// with it. The stages are: unary ops on the inputs, the first combine with the
// middle unary, then the second combine with the final unary. Configuration
// writes take effect on the next clock; the user must make them while no word
// is in flight, as the block itself does not enforce this.
module packed_pixel_raster_op_combiner_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [prpc_pkg::CIDX_W-1:0]   cfg_index,
	input  logic [prpc_pkg::CDATA_W-1:0]  cfg_data,
	input  logic                          start,
	output logic                          busy,
	input  logic [prpc_pkg::BYTE_W-1:0]   source_byte,
	input  logic [prpc_pkg::BYTE_W-1:0]   mask_byte,
	input  logic [prpc_pkg::BYTE_W-1:0]   dest_byte,
	output logic                          done,
	output logic [prpc_pkg::BYTE_W-1:0]   result_byte
);
	import prpc_pkg::*;

	cfg_t              cfg;
	stage_ctl_t        ctl_first;
	stage_ctl_t        ctl_second;
	logic              accept;
	logic              v_s1;
	logic [BYTE_W-1:0] s_s1;
	logic [BYTE_W-1:0] m_s1;
	logic [BYTE_W-1:0] d_s1;
	logic              v_s2;
	logic [BYTE_W-1:0] i_s2;
	logic [BYTE_W-1:0] d_s2;

	assign busy   = 1'b0;
	assign accept = start & ~busy;

	prpc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	prpc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (accept),
		.src       (source_byte),
		.msk       (mask_byte),
		.dst       (dest_byte),
		.cfg       (cfg),
		.out_valid (v_s1),
		.s_out     (s_s1),
		.m_out     (m_s1),
		.d_out     (d_s1)
	);

	assign ctl_first.pixel_mode  = cfg.pixel_mode;
	assign ctl_first.bop         = cfg.first_bop;
	assign ctl_first.uop         = cfg.middle_uop;
	assign ctl_second.pixel_mode = cfg.pixel_mode;
	assign ctl_second.bop        = cfg.second_bop;
	assign ctl_second.uop        = cfg.final_uop;

	prpc_combine u_first (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s1),
		.a         (s_s1),
		.b         (m_s1),
		.ctl       (ctl_first),
		.out_valid (v_s2),
		.y         (i_s2)
	);

	// carry the processed destination word alongside the first combine
	always_ff @(posedge clk) begin
		if (v_s1) begin
			d_s2 <= d_s1;
		end
	end

	prpc_combine u_second (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s2),
		.a         (i_s2),
		.b         (d_s2),
		.ctl       (ctl_second),
		.out_valid (done),
		.y         (result_byte)
	);

`ifndef SYNTHESIS
	a_start_gives_done: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##3 done)
		else $error("accepted word did not complete after three cycles");

	a_done_has_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, 3))
		else $error("done without a word accepted three cycles before");

	a_s2_follows_s1: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> $past(v_s1))
		else $error("second stage valid without first stage valid");
`endif

endmodule

@@ bench/tb_packed_pixel_raster_op_combiner_top.sv @@
// Testbench: raster op combiner checked word by word against a behavioural predictor.
`timescale 1ns / 1ps

module tb_packed_pixel_raster_op_combiner_top;
	import prpc_pkg::*;

	typedef logic [BYTE_W-1:0] pix_t;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int RANDOM_ITEMS = 930;
	localparam int DRAIN_CYCLES = 8;

	// mode three is decoded as four bits per pixel
	localparam logic [MODE_W-1:0] MODE_4BPP_ALIAS = 2'd3;
	localparam logic [BOP_W-1:0]  BOP_VOID_LO     = 3'd6;
	localparam logic [BOP_W-1:0]  BOP_VOID_HI     = 3'd7;

	// unary codes per depth: colour count plus the offset from the package
	localparam logic [UOP_W-1:0] COPY_1    = 5'd2 + UOP_COPY;
	localparam logic [UOP_W-1:0] NOT_1     = 5'd2 + UOP_NOT;
	localparam logic [UOP_W-1:0] ZERO_1    = 5'd2 + UOP_ZERO;
	localparam logic [UOP_W-1:0] THRESH_1  = 5'd2 + UOP_THRESH;
	localparam logic [UOP_W-1:0] COPY_2    = 5'd4 + UOP_COPY;
	localparam logic [UOP_W-1:0] NOT_2     = 5'd4 + UOP_NOT;
	localparam logic [UOP_W-1:0] THRESH_2  = 5'd4 + UOP_THRESH;
	localparam logic [UOP_W-1:0] COPY_4    = 5'd16 + UOP_COPY;
	localparam logic [UOP_W-1:0] NOT_4     = 5'd16 + UOP_NOT;
	localparam logic [UOP_W-1:0] THRESH_4  = 5'd16 + UOP_THRESH;
	localparam logic [UOP_W-1:0] UNUSED_4  = 5'd16 + UOP_THRESH + 5'd1;
	localparam logic [UOP_W-1:0] UOP_TOP   = 5'd31;

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic [CIDX_W-1:0]   cfg_index;
	logic [CDATA_W-1:0]  cfg_data;
	logic                start;
	logic                busy;
	pix_t                source_byte;
	pix_t                mask_byte;
	pix_t                dest_byte;
	logic                done;
	pix_t                result_byte;

	packed_pixel_raster_op_combiner_top u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.start       (start),
		.busy        (busy),
		.source_byte (source_byte),
		.mask_byte   (mask_byte),
		.dest_byte   (dest_byte),
		.done        (done),
		.result_byte (result_byte)
	);

	typedef struct {
		cfg_t setup;
		pix_t src;
		pix_t msk;
		pix_t dst;
		bit   typed;
		pix_t want;
	} trial_t;

	cfg_t   active_settings;
	pix_t   pending_results[$];
	trial_t trials[$];
	int     fault_count;
	int     burst_left;
	int     items_sent;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// ---------------- predictor ----------------

	function automatic int colour_count(input logic [MODE_W-1:0] mode);
		case (mode)
			MODE_1BPP: return 2;
			MODE_2BPP: return 4;
			default:   return 16;
		endcase
	endfunction

	function automatic pix_t spread_colour(input logic [3:0] c, input logic [MODE_W-1:0] mode);
		pix_t v;
		v = '0;
		case (mode)
			MODE_1BPP: v = (c != 4'd0) ? 8'hff : 8'h00;
			MODE_2BPP: begin
				if (c[0]) v |= 8'h0f;
				if (c[1]) v |= 8'hf0;
			end
			default: begin
				if (c[3]) v |= 8'h03;
				if (c[1]) v |= 8'h0c;
				if (c[2]) v |= 8'h30;
				if (c[0]) v |= 8'hc0;
			end
		endcase
		return v;
	endfunction

	// any set bit of a pixel lights the whole pixel
	function automatic pix_t widen_groups(input pix_t v, input logic [MODE_W-1:0] mode);
		pix_t r;
		r = '0;
		case (mode)
			MODE_1BPP: r = v;
			MODE_2BPP: begin
				if ((v & 8'h11) != 0) r |= 8'h11;
				if ((v & 8'h22) != 0) r |= 8'h22;
				if ((v & 8'h44) != 0) r |= 8'h44;
				if ((v & 8'h88) != 0) r |= 8'h88;
			end
			default: begin
				if ((v & 8'haa) != 0) r |= 8'haa;
				if ((v & 8'h55) != 0) r |= 8'h55;
			end
		endcase
		return r;
	endfunction

	function automatic pix_t apply_unary(input logic [UOP_W-1:0] op, input pix_t a,
			input logic [MODE_W-1:0] mode);
		int p;
		p = colour_count(mode);
		if (op < p)                       return spread_colour(op[3:0], mode);
		if (op == p + int'(UOP_COPY))     return a;
		if (op == p + int'(UOP_NOT))      return ~a;
		if (op == p + int'(UOP_ZERO))     return '0;
		if (op == p + int'(UOP_THRESH))   return widen_groups(a, mode);
		return '0;
	endfunction

	function automatic pix_t apply_combine(input logic [BOP_W-1:0] op, input pix_t a,
			input pix_t b, input logic [MODE_W-1:0] mode);
		case (op)
			BOP_AND:    return a & b;
			BOP_OR:     return a | b;
			BOP_XOR:    return a ^ b;
			BOP_FIRST:  return a;
			BOP_SECOND: return b;
			BOP_PMASK:  return a & widen_groups(b, mode);
			default:    return '0;
		endcase
	endfunction

	function automatic pix_t predict_result(input cfg_t c, input pix_t s, input pix_t m,
			input pix_t d);
		pix_t first_mix;
		pix_t second_mix;
		first_mix = apply_combine(c.first_bop, apply_unary(c.source_uop, s, c.pixel_mode),
			apply_unary(c.mask_uop, m, c.pixel_mode), c.pixel_mode);
		second_mix = apply_combine(c.second_bop,
			apply_unary(c.middle_uop, first_mix, c.pixel_mode),
			apply_unary(c.dest_uop, d, c.pixel_mode), c.pixel_mode);
		return apply_unary(c.final_uop, second_mix, c.pixel_mode);
	endfunction

	// ---------------- settings ----------------

	function automatic cfg_t settings(input logic [MODE_W-1:0] mode,
			input logic [UOP_W-1:0] su, input logic [UOP_W-1:0] mu,
			input logic [BOP_W-1:0] fb, input logic [UOP_W-1:0] iu,
			input logic [UOP_W-1:0] du, input logic [BOP_W-1:0] sb,
			input logic [UOP_W-1:0] fu);
		cfg_t c;
		c.pixel_mode = mode;
		c.source_uop = su;
		c.mask_uop   = mu;
		c.first_bop  = fb;
		c.middle_uop = iu;
		c.dest_uop   = du;
		c.second_bop = sb;
		c.final_uop  = fu;
		return c;
	endfunction

	// favour pass-through codes so that data reaches the output
	function automatic logic [UOP_W-1:0] random_uop(input int p);
		int pick;
		pick = $urandom_range(0, 19);
		if (pick < 10) begin
			case ($urandom_range(0, 2))
				0:       return UOP_W'(p + int'(UOP_COPY));
				1:       return UOP_W'(p + int'(UOP_NOT));
				default: return UOP_W'(p + int'(UOP_THRESH));
			endcase
		end
		if (pick < 17) return UOP_W'($urandom_range(0, p + 3));
		return UOP_W'($urandom_range(0, 31));
	endfunction

	function automatic logic [BOP_W-1:0] random_bop();
		if ($urandom_range(0, 7) == 0) return BOP_W'($urandom_range(0, 7));
		return BOP_W'($urandom_range(0, 5));
	endfunction

	function automatic cfg_t random_settings();
		cfg_t c;
		int p;
		c.pixel_mode = MODE_W'($urandom_range(0, 3));
		p = colour_count(c.pixel_mode);
		c.source_uop = random_uop(p);
		c.mask_uop   = random_uop(p);
		c.first_bop  = random_bop();
		c.middle_uop = random_uop(p);
		c.dest_uop   = random_uop(p);
		c.second_bop = random_bop();
		c.final_uop  = random_uop(p);
		return c;
	endfunction

	function automatic pix_t random_pix();
		case ($urandom_range(0, 7))
			0:       return 8'h00;
			1:       return 8'hff;
			default: return pix_t'($urandom_range(0, 255));
		endcase
	endfunction

	// spare data bits above a narrow register carry noise, which must be dropped
	function automatic logic [CDATA_W-1:0] register_word(input cfg_t c,
			input logic [CIDX_W-1:0] idx, input logic [CDATA_W-1:0] noise);
		case (idx)
			REG_PIXEL_MODE: return {noise[CDATA_W-1:MODE_W], c.pixel_mode};
			REG_SOURCE_UOP: return c.source_uop;
			REG_MASK_UOP:   return c.mask_uop;
			REG_FIRST_BOP:  return {noise[CDATA_W-1:BOP_W], c.first_bop};
			REG_MIDDLE_UOP: return c.middle_uop;
			REG_DEST_UOP:   return c.dest_uop;
			REG_SECOND_BOP: return {noise[CDATA_W-1:BOP_W], c.second_bop};
			default:        return c.final_uop;
		endcase
	endfunction

	// ---------------- driving ----------------

	task automatic load_settings(input cfg_t c, input logic [CDATA_W-1:0] noise);
		for (int r = 0; r < 8; r++) begin
			cfg_we    <= 1'b1;
			cfg_index <= CIDX_W'(r);
			cfg_data  <= register_word(c, CIDX_W'(r), noise);
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		active_settings = c;
	endtask

	// hold start low until every word in flight has come back
	task automatic settle();
		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic push_word(input pix_t s, input pix_t m, input pix_t d, input bit typed,
			input pix_t want);
		start       <= 1'b1;
		source_byte <= s;
		mask_byte   <= m;
		dest_byte   <= d;
		do @(posedge clk); while (busy !== 1'b0);
		pending_results.push_back(typed ? want : predict_result(active_settings, s, m, d));
	endtask

	task automatic pace_sender();
		int gap;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
				: $urandom_range(0, 10);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic run_phase(input cfg_t c, input logic [CDATA_W-1:0] noise, input int n);
		settle();
		load_settings(c, noise);
		repeat (n) begin
			push_word(random_pix(), random_pix(), random_pix(), 1'b0, '0);
			pace_sender();
		end
		items_sent += n;
	endtask

	task automatic add_trial(input cfg_t c, input pix_t s, input pix_t m, input pix_t d,
			input bit typed, input pix_t want);
		trial_t t;
		t.setup = c;
		t.src   = s;
		t.msk   = m;
		t.dst   = d;
		t.typed = typed;
		t.want  = want;
		trials.push_back(t);
	endtask

	// ---------------- result check ----------------

	always @(posedge clk) begin
		pix_t want;
		if (arst_n && done === 1'b1) begin
			if (pending_results.size() == 0) begin
				$display("%0t: word with none waiting: expected none, actual %h", $time,
					result_byte);
				fault_count++;
			end else begin
				want = pending_results.pop_front();
				if (result_byte !== want) begin
					$display("%0t: result_byte mismatch: expected %h, actual %h", $time,
						want, result_byte);
					fault_count++;
				end
			end
		end
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("** packed_pixel_raster_op_combiner_top: FAILED **");
		$finish;
	end

	// ---------------- sequence ----------------

	initial begin
		cfg_t reset_cfg;
		reset_cfg = settings(MODE_1BPP, UOP_RESET, UOP_RESET, BOP_RESET, UOP_RESET, UOP_RESET,
			BOP_RESET, UOP_RESET);
		active_settings = reset_cfg;
		fault_count = 0;
		burst_left  = 0;
		items_sent  = 0;

		arst_n      <= 1'b0;
		cfg_we      <= 1'b0;
		cfg_index   <= '0;
		cfg_data    <= '0;
		start       <= 1'b0;
		source_byte <= '0;
		mask_byte   <= '0;
		dest_byte   <= '0;

		// values straight after reset
		add_trial(reset_cfg, 8'ha5, 8'h3c, 8'hc3, 1'b1, 8'ha5);
		add_trial(reset_cfg, 8'h00, 8'hff, 8'hff, 1'b1, 8'h00);
		add_trial(reset_cfg, 8'hff, 8'h00, 8'h00, 1'b1, 8'hff);
		// one bit per pixel
		add_trial(settings(MODE_1BPP, NOT_1, COPY_1, BOP_FIRST, COPY_1, COPY_1, BOP_FIRST,
			COPY_1), 8'h0f, 8'h55, 8'haa, 1'b1, 8'hf0);
		add_trial(settings(MODE_1BPP, COPY_1, COPY_1, BOP_FIRST, COPY_1, COPY_1, BOP_FIRST,
			5'd1), 8'h00, 8'h00, 8'h00, 1'b1, 8'hff);
		add_trial(settings(MODE_1BPP, COPY_1, COPY_1, BOP_FIRST, COPY_1, COPY_1, BOP_FIRST,
			5'd0), 8'hff, 8'hff, 8'hff, 1'b1, 8'h00);
		add_trial(settings(MODE_1BPP, COPY_1, COPY_1, BOP_FIRST, COPY_1, COPY_1, BOP_FIRST,
			ZERO_1), 8'hff, 8'hff, 8'hff, 1'b1, 8'h00);
		add_trial(settings(MODE_1BPP, COPY_1, COPY_1, BOP_FIRST, COPY_1, COPY_1, BOP_FIRST,
			UOP_TOP), 8'hff, 8'hff, 8'hff, 1'b1, 8'h00);
		add_trial(settings(MODE_1BPP, COPY_1, COPY_1, BOP_FIRST, COPY_1, COPY_1, BOP_VOID_HI,
			COPY_1), 8'hff, 8'hff, 8'hff, 1'b1, 8'h00);
		add_trial(settings(MODE_1BPP, COPY_1, COPY_1, BOP_VOID_LO, COPY_1, COPY_1, BOP_FIRST,
			COPY_1), 8'hff, 8'hff, 8'hff, 1'b1, 8'h00);
		add_trial(settings(MODE_1BPP, COPY_1, COPY_1, BOP_AND, COPY_1, COPY_1, BOP_OR,
			COPY_1), 8'h5a, 8'h3c, 8'h81, 1'b0, '0);
		add_trial(settings(MODE_1BPP, THRESH_1, COPY_1, BOP_XOR, COPY_1, NOT_1, BOP_SECOND,
			COPY_1), 8'h96, 8'h0f, 8'h3c, 1'b0, '0);
		add_trial(settings(MODE_1BPP, COPY_1, COPY_1, BOP_PMASK, THRESH_1, COPY_1, BOP_PMASK,
			NOT_1), 8'hf3, 8'h6e, 8'hb5, 1'b0, '0);
		// two bits per pixel
		add_trial(settings(MODE_2BPP, COPY_2, COPY_2, BOP_FIRST, COPY_2, COPY_2, BOP_FIRST,
			5'd2), 8'h00, 8'h00, 8'h00, 1'b1, 8'hf0);
		add_trial(settings(MODE_2BPP, COPY_2, COPY_2, BOP_FIRST, COPY_2, COPY_2, BOP_FIRST,
			5'd3), 8'h00, 8'h00, 8'h00, 1'b1, 8'hff);
		add_trial(settings(MODE_2BPP, THRESH_2, COPY_2, BOP_FIRST, COPY_2, COPY_2, BOP_FIRST,
			COPY_2), 8'h01, 8'h00, 8'h00, 1'b1, 8'h11);
		add_trial(settings(MODE_2BPP, COPY_2, COPY_2, BOP_PMASK, COPY_2, COPY_2, BOP_FIRST,
			COPY_2), 8'hff, 8'h10, 8'h00, 1'b0, '0);
		add_trial(settings(MODE_2BPP, NOT_2, THRESH_2, BOP_AND, COPY_2, NOT_2, BOP_XOR,
			THRESH_2), 8'h4d, 8'h82, 8'h27, 1'b0, '0);
		// four bits per pixel
		add_trial(settings(MODE_4BPP, COPY_4, COPY_4, BOP_FIRST, COPY_4, COPY_4, BOP_FIRST,
			5'd15), 8'h00, 8'h00, 8'h00, 1'b1, 8'hff);
		add_trial(settings(MODE_4BPP, COPY_4, COPY_4, BOP_FIRST, COPY_4, COPY_4, BOP_FIRST,
			5'd8), 8'h00, 8'h00, 8'h00, 1'b1, 8'h03);
		add_trial(settings(MODE_4BPP, COPY_4, COPY_4, BOP_FIRST, COPY_4, COPY_4, BOP_FIRST,
			5'd1), 8'h00, 8'h00, 8'h00, 1'b1, 8'hc0);
		add_trial(settings(MODE_4BPP, THRESH_4, COPY_4, BOP_FIRST, COPY_4, COPY_4, BOP_FIRST,
			COPY_4), 8'h02, 8'h00, 8'h00, 1'b1, 8'haa);
		add_trial(settings(MODE_4BPP, COPY_4, COPY_4, BOP_FIRST, COPY_4, COPY_4, BOP_FIRST,
			UNUSED_4), 8'hff, 8'hff, 8'hff, 1'b1, 8'h00);
		add_trial(settings(MODE_4BPP_ALIAS, COPY_4, COPY_4, BOP_FIRST, COPY_4, COPY_4,
			BOP_FIRST, 5'd4), 8'h00, 8'h00, 8'h00, 1'b1, 8'h30);
		add_trial(settings(MODE_4BPP_ALIAS, THRESH_4, NOT_4, BOP_PMASK, THRESH_4, COPY_4,
			BOP_OR, NOT_4), 8'h14, 8'he1, 8'h39, 1'b0, '0);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (trials[k]) begin
			if (trials[k].setup != active_settings) begin
				settle();
				load_settings(trials[k].setup, '0);
			end
			push_word(trials[k].src, trials[k].msk, trials[k].dst, trials[k].typed,
				trials[k].want);
			pace_sender();
		end

		// extremes of every register, then random settings
		run_phase(settings(MODE_4BPP_ALIAS, UOP_TOP, UOP_TOP, BOP_VOID_HI, UOP_TOP, UOP_TOP,
			BOP_VOID_HI, UOP_TOP), 5'h1f, 20);
		run_phase(settings(MODE_1BPP, 5'd0, 5'd0, BOP_AND, 5'd0, 5'd0, BOP_AND, 5'd0), '0, 20);
		while (items_sent < RANDOM_ITEMS) begin
			run_phase(random_settings(), ($urandom_range(0, 1) == 0) ? '0
				: CDATA_W'($urandom_range(0, 31)), $urandom_range(30, 70));
		end

		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fault_count == 0) begin
			$display("** packed_pixel_raster_op_combiner_top: PASSED **");
		end else begin
			$display("** packed_pixel_raster_op_combiner_top: FAILED **");
		end
		$finish;
	end

endmodule
